/* design/k_stacks_shared_buffer_assert.svh */
// Assertion macros for the shared stack buffer
`ifndef K_STACKS_SHARED_BUFFER_ASSERT_SVH
`define K_STACKS_SHARED_BUFFER_ASSERT_SVH

// same-cycle implication
`define KSB_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ksb: implication failed");

// next-cycle implication
`define KSB_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ksb: next-cycle check failed");

`endif

/* design/ksb_pkg.sv */
// Package: constants, types and codes of the shared stack buffer
`default_nettype none
package ksb_pkg;

   localparam int NUM_STACKS = 4;
   localparam int CAPACITY   = 16;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int PTR_W  = $clog2(CAPACITY + 1);
   localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int DATA_W = 32;

   localparam logic [PTR_W-1:0]         SLOT_NULL       = PTR_W'(CAPACITY);
   localparam logic signed [DATA_W-1:0] UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage
`default_nettype wire

/* design/ksb_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module ksb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/ksb_ctrl.sv */
// Controller: two-state sequencer and result-beat handshake
`default_nettype none
`include "k_stacks_shared_buffer_assert.svh"
module ksb_ctrl
   import ksb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = rsp_valid_ff && rsp_stall;
            cmd.capture = req_valid && !(rsp_valid_ff && rsp_stall);
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = cmd.capture;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `KSB_ASSERT_NEXT(a_capture_then_commit, accept, cmd.commit)
   `KSB_ASSERT_IMPL(a_commit_into_free_slot, cmd.commit, !(rsp_valid_ff && rsp_stall))
   `KSB_ASSERT_IMPL(a_no_beat_during_exec, state_ff == ST_EXEC, req_stall)
   `KSB_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid)

endmodule
`default_nettype wire

/* design/ksb_dpath.sv */
// Datapath: head pointers, free-list head, slot stores and result register
`default_nettype none
module ksb_dpath
   import ksb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic                     req_operation,
   input  wire logic [1:0]               req_stack_id,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic signed [DATA_W-1:0]      rsp_pop_value,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_all_full
);

   logic [PTR_W-1:0]  head_ff [NUM_STACKS];
   logic [PTR_W-1:0]  head_in [NUM_STACKS];
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [CAPACITY-1:0] link_ok_ff, link_ok_in;

   logic                     op_ff;
   logic [SIDX_W-1:0]        sidx_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [PTR_W-1:0]         slot_ff;
   logic                     ok_ff;
   logic                     link_hit_ff;

   logic signed [DATA_W-1:0] pop_value_ff, pop_value_in;
   status_type               status_ff, status_in;
   logic                     all_full_ff, all_full_in;

   logic [SIDX_W-1:0] cap_sidx;
   logic              cap_sid_ok;
   logic [PTR_W-1:0]  cap_ptr;
   logic              cap_ok;
   logic [ADDR_W-1:0] cap_addr;
   logic [ADDR_W-1:0] slot_addr;

   logic [DATA_W-1:0] data_rd;
   logic [PTR_W-1:0]  link_q;
   logic [PTR_W-1:0]  link_rd;
   logic              data_we;
   logic              link_we;
   logic [PTR_W-1:0]  link_wdata;

   // pick the slot this beat works on
   always_comb begin
      cap_sidx   = SIDX_W'(req_stack_id);
      cap_sid_ok = int'(req_stack_id) < NUM_STACKS;
      if (req_operation == OP_POP && cap_sid_ok) begin
         cap_ptr = head_ff[cap_sidx];
      end else begin
         cap_ptr = free_head_ff;
      end
      cap_ok   = cap_sid_ok && (cap_ptr < SLOT_NULL);
      cap_addr = cap_ptr[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         sidx_ff     <= cap_sidx;
         value_ff    <= req_push_value;
         slot_ff     <= cap_ptr;
         ok_ff       <= cap_ok;
         link_hit_ff <= link_ok_ff[cap_addr];
      end
   end

   assign slot_addr = slot_ff[ADDR_W-1:0];
   assign link_rd   = link_hit_ff ? link_q : PTR_W'(slot_ff + PTR_W'(1));

   assign data_we    = cmd.commit && ok_ff && (op_ff == OP_PUSH);
   assign link_we    = cmd.commit && ok_ff;
   assign link_wdata = (op_ff == OP_PUSH) ? head_ff[sidx_ff] : free_head_ff;

   ksb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (slot_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.capture),
      .rd_addr (cap_addr),
      .rd_data (data_rd)
   );

   ksb_ram #(
      .WIDTH (PTR_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (slot_addr),
      .wr_data (link_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (cap_addr),
      .rd_data (link_q)
   );

   // relink on commit
   always_comb begin
      head_in      = head_ff;
      free_head_in = free_head_ff;
      link_ok_in   = link_ok_ff;
      if (link_we) begin
         link_ok_in[slot_addr] = 1'b1;
         if (op_ff == OP_PUSH) begin
            free_head_in     = link_rd;
            head_in[sidx_ff] = slot_ff;
         end else begin
            head_in[sidx_ff] = link_rd;
            free_head_in     = slot_ff;
         end
      end
   end

   always_comb begin
      if (op_ff == OP_PUSH) begin
         pop_value_in = '0;
         status_in    = ok_ff ? STATUS_OK : STATUS_OVERFLOW;
      end else if (ok_ff) begin
         pop_value_in = data_rd;
         status_in    = STATUS_OK;
      end else begin
         pop_value_in = UNDERFLOW_VALUE;
         status_in    = STATUS_UNDERFLOW;
      end
      all_full_in = !(free_head_in < SLOT_NULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            head_ff[i] <= SLOT_NULL;
         end
         free_head_ff <= '0;
         link_ok_ff   <= '0;
      end else begin
         head_ff      <= head_in;
         free_head_ff <= free_head_in;
         link_ok_ff   <= link_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pop_value_ff <= pop_value_in;
         status_ff    <= status_in;
         all_full_ff  <= all_full_in;
      end
   end

   assign rsp_pop_value = pop_value_ff;
   assign rsp_status    = status_ff;
   assign rsp_all_full  = all_full_ff;

endmodule
`default_nettype wire

/* design/k_stacks_shared_buffer.sv */
// A request is captured in ST_IDLE, committed in ST_EXEC, and its result registered and
//   offered; a new one is taken only after the last commits. Each takes a registered
//   read of the slot's link and data words, then a write-back and head-pointer update.
// A result held by rsp_stall stalls the request side until it is taken.
// Reset: stacks empty, free-list head at slot zero, link valid bits cleared; ready at once.
`default_nettype none
module k_stacks_shared_buffer
   import ksb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_operation,
   input  wire logic [1:0]               req_stack_id,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_pop_value,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_all_full
);

   cmd_type cmd;

   ksb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ksb_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_all_full   (rsp_all_full)
   );

endmodule
`default_nettype wire

/* tb/k_stacks_shared_buffer_tb.sv */
// Testbench: shared-buffer stacks, predicted push/pop results checked beat by beat
`timescale 1ns / 100ps
module k_stacks_shared_buffer_tb;
   import ksb_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] pop_value;
      status_type               status;
      logic                     all_full;
   } stack_outcome_type;

   class stack_scoreboard;
      logic signed [DATA_W-1:0] slot_data [CAPACITY];
      logic [PTR_W-1:0]         slot_link [CAPACITY];
      logic [PTR_W-1:0]         stack_head [NUM_STACKS];
      logic [PTR_W-1:0]         free_head;
      stack_outcome_type        pending [$];
      int                       errors;

      function new();
         for (int i = 0; i < CAPACITY; i++) begin
            slot_data[i] = '0;
            slot_link[i] = PTR_W'(i + 1);
         end
         slot_link[CAPACITY-1] = SLOT_NULL;
         for (int i = 0; i < NUM_STACKS; i++) stack_head[i] = SLOT_NULL;
         free_head = '0;
         errors    = 0;
      endfunction

      function void note_request(logic op, logic [1:0] sid, logic signed [DATA_W-1:0] value);
         stack_outcome_type o;
         logic [PTR_W-1:0]  s;
         o.pop_value = '0;
         o.status    = STATUS_OK;
         if (op == OP_PUSH) begin
            if (int'(sid) >= NUM_STACKS || free_head >= CAPACITY) begin
               o.status = STATUS_OVERFLOW;
            end else begin
               s               = free_head;
               free_head       = slot_link[s];
               slot_link[s]    = stack_head[sid];
               stack_head[sid] = s;
               slot_data[s]    = value;
            end
         end else begin
            if (int'(sid) >= NUM_STACKS || stack_head[sid] >= CAPACITY) begin
               o.status    = STATUS_UNDERFLOW;
               o.pop_value = UNDERFLOW_VALUE;
            end else begin
               s               = stack_head[sid];
               stack_head[sid] = slot_link[s];
               slot_link[s]    = free_head;
               free_head       = s;
               o.pop_value     = slot_data[s];
            end
         end
         o.all_full = (free_head >= CAPACITY);
         pending.push_back(o);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] pop_value, logic [1:0] status,
                                 logic all_full);
         stack_outcome_type o;
         if (pending.size() == 0) begin
            $display("%0t: result beat with nothing expected: pop_value %0d status %0d full %0b",
                     $time, pop_value, status, all_full);
            errors++;
            return;
         end
         o = pending.pop_front();
         if (pop_value !== o.pop_value) begin
            $display("%0t: pop_value expected %0d actual %0d", $time, o.pop_value, pop_value);
            errors++;
         end
         if (status !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, status);
            errors++;
         end
         if (all_full !== o.all_full) begin
            $display("%0t: all_full expected %0b actual %0b", $time, o.all_full, all_full);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_operation = OP_PUSH;
   logic [1:0]               req_stack_id = '0;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_pop_value;
   logic [1:0]               rsp_status;
   logic                     rsp_all_full;

   logic                     calm = 1'b0;
   stack_scoreboard          sb = new();

   k_stacks_shared_buffer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_all_full   (rsp_all_full)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_beat(logic op, logic [1:0] sid, logic signed [DATA_W-1:0] value);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_stack_id   <= sid;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, sid, value);
   endtask

   task automatic run_phase(int count, int push_pct, int focus);
      logic       op;
      logic [1:0] sid;
      for (int n = 0; n < count; n++) begin
         op  = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
         sid = (focus >= 0 && $urandom_range(99) < 80) ? 2'(focus) : 2'($urandom_range(3));
         send_beat(op, sid, $urandom());
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_pop_value, rsp_status, rsp_all_full);
         rsp_stall <= !calm && ($urandom_range(99) < 22);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_STACKS; i++) send_beat(OP_POP, 2'(i), $urandom());
      send_beat(OP_PUSH, 2'd0, 32'sh7FFF_FFFF);
      send_beat(OP_PUSH, 2'd1, 32'sh8000_0000);
      send_beat(OP_PUSH, 2'd2, -32'sd1);
      send_beat(OP_PUSH, 2'd3, 32'sd0);
      send_beat(OP_PUSH, 2'd0, 32'sh5555_5555);
      send_beat(OP_PUSH, 2'd0, 32'shAAAA_AAAA);
      send_beat(OP_POP, 2'd0, '0);
      send_beat(OP_POP, 2'd0, '1);
      send_beat(OP_POP, 2'd0, '0);
      send_beat(OP_POP, 2'd1, '1);
      send_beat(OP_POP, 2'd2, '0);
      send_beat(OP_POP, 2'd3, '1);
      send_beat(OP_POP, 2'd0, '0);

      run_phase(200, 50, -1);
      run_phase(150, 85, -1);
      run_phase(150, 15, -1);
      run_phase(100, 80, 2);
      run_phase(100, 25, 2);
      calm = 1'b1;
      run_phase(300, 50, -1);
      calm = 1'b0;
      run_phase(150, 90, 1);
      run_phase(150, 10, -1);
      run_phase(250, 55, -1);

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/ksb_pkg.sv
design/ksb_ram.sv
design/ksb_ctrl.sv
design/ksb_dpath.sv
design/k_stacks_shared_buffer.sv
tb/k_stacks_shared_buffer_tb.sv
